[design/rnpi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rnpi_pkg
// Shared types and constants for the RGB555 nearest palette index search.
// ----------------------------------------------------------------------------
package rnpi_pkg;

  localparam int unsigned PaletteEntriesDef = 256;

  localparam int unsigned ChanW   = 8;   // palette channel byte
  localparam int unsigned SlotW   = 8;   // palette slot / result index
  localparam int unsigned ColorW  = 15;  // packed RGB555 query colour
  localparam int unsigned FieldW  = 5;   // one RGB555 channel
  localparam int unsigned SqW     = 16;  // one squared channel difference
  localparam int unsigned DistW   = 18;  // sum of three squares

  // operation field codes
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // One beat travelling down the cell chain: either a palette load or a
  // query carrying the running best match.
  typedef struct packed {
    logic              valid;
    logic              is_load;
    logic [SlotW-1:0]  slot;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
    logic [ColorW-1:0] color15;
    logic [DistW-1:0]  best_dist;
    logic [SlotW-1:0]  best_idx;
  } beat_t;

endpackage : rnpi_pkg
`default_nettype wire

[design/rnpi_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rnpi_cell
// One palette slot of the search chain. Holds its entry, captures loads
// addressed to it and folds its distance into passing queries.
// ----------------------------------------------------------------------------
module rnpi_cell
  import rnpi_pkg::*;
#(
  parameter int unsigned CellIndex = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  adv_i,
  input  wire beat_t beat_i,
  output beat_t      beat_o
);

  localparam logic [SlotW-1:0] SlotId = SlotW'(CellIndex);
  localparam bit IsFirst = (CellIndex == 0);

  // squared difference between a widened 5-bit channel and a palette byte
  function automatic logic [SqW-1:0] sq_diff(input logic [FieldW-1:0] q,
                                             input logic [ChanW-1:0]  e);
    logic signed [ChanW:0]     d;
    logic signed [2*ChanW+1:0] p;
    begin
      d = $signed({1'b0, q, 3'b100}) - $signed({1'b0, e});
      p = d * d;
      sq_diff = p[SqW-1:0];
    end
  endfunction

  logic [ChanW-1:0] red_q, green_q, blue_q;
  beat_t            s1_q, s2_d, s2_q;
  logic [DistW-1:0] dist_d, dist_q;

  // palette entry: written as a load beat enters this cell, so beats in
  // flight see loads in arrival order
  always_ff @(posedge clk_i) begin
    if (adv_i && beat_i.valid && beat_i.is_load && (beat_i.slot == SlotId)) begin
      red_q   <= beat_i.red;
      green_q <= beat_i.green;
      blue_q  <= beat_i.blue;
    end
  end

  always_comb begin
    dist_d = DistW'(sq_diff(beat_i.color15[FieldW-1:0], red_q))
           + DistW'(sq_diff(beat_i.color15[2*FieldW-1:FieldW], green_q))
           + DistW'(sq_diff(beat_i.color15[3*FieldW-1:2*FieldW], blue_q));
  end

  always_comb begin
    s2_d = s1_q;
    if (s1_q.valid && !s1_q.is_load && (IsFirst || (dist_q < s1_q.best_dist))) begin
      s2_d.best_dist = dist_q;
      s2_d.best_idx  = SlotId;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else if (adv_i) begin
      s1_q <= beat_i;
      s2_q <= s2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dist_q <= dist_d;
    end
  end

  assign beat_o = s2_q;

endmodule : rnpi_cell
`default_nettype wire

[design/rgb555_nearest_palette_index.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rgb555_nearest_palette_index
// Nearest palette colour search for RGB555 pixels.
// ----------------------------------------------------------------------------
// Each palette slot lives in its own cell of a chain of PALETTE_ENTRIES cells.
// Every beat, load or query, walks the chain one cell stage at a time; a load
// is captured by the cell whose slot it names (slots at or beyond
// PALETTE_ENTRIES are dropped), and a query picks up the distance to each
// entry in turn, keeping the lowest index on ties. One beat is taken per
// clock while the chain is not stalled. A query's beat enters the first
// cell's first stage at the accepting edge, takes two register stages per
// cell (squares and sum, then compare), and the last cell hands it to the
// output register. Loads give no result. The whole chain stalls only while
// a result waits in the output register. Queries must not be issued until
// every slot has been loaded.
// ----------------------------------------------------------------------------
module rgb555_nearest_palette_index
  import rnpi_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PaletteEntriesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [SlotW-1:0]  entry_index_i,
  input  wire logic [ChanW-1:0]  red_i,
  input  wire logic [ChanW-1:0]  green_i,
  input  wire logic [ChanW-1:0]  blue_i,
  input  wire logic [ColorW-1:0] color15_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [SlotW-1:0]       nearest_index_o
);

  beat_t            link [PALETTE_ENTRIES+1];
  beat_t            head;
  logic             adv;
  logic             out_valid_q;
  logic [SlotW-1:0] nearest_q;
  beat_t            last;

  assign adv = !out_valid_q || out_ready_i;

  always_comb begin
    head           = '0;
    head.valid     = in_valid_i;
    head.is_load   = (operation_i == OpLoad);
    head.slot      = entry_index_i;
    head.red       = red_i;
    head.green     = green_i;
    head.blue      = blue_i;
    head.color15   = color15_i;
  end

  assign link[0] = head;

  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    rnpi_cell #(
      .CellIndex(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .beat_i (link[g]),
      .beat_o (link[g+1])
    );
  end

  assign last = link[PALETTE_ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= last.valid && !last.is_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last.valid) begin
      nearest_q <= last.best_idx;
    end
  end

  assign in_ready_o      = adv;
  assign out_valid_o     = out_valid_q;
  assign nearest_index_o = nearest_q;

endmodule : rgb555_nearest_palette_index
`default_nettype wire

[sim/rgb555_nearest_palette_index_test.sv]
// ----------------------------------------------------------------------------
// rgb555_nearest_palette_index_test
// Self-checking bench for the RGB555 nearest palette index search. The palette
// is filled first, then extreme colours and ties on duplicate entries are
// queried. After that comes mixed load/query traffic under four idling
// patterns. A local palette mirror gives the expected index of every query,
// and each result beat is compared in order.
// ----------------------------------------------------------------------------
module rgb555_nearest_palette_index_test;
  import rnpi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseBeats = 340;
  localparam int unsigned ChainDelay = 2 * PaletteEntriesDef + 16;
  localparam int unsigned DrainLimit = 200000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  logic              operation = OpLoad;
  logic [SlotW-1:0]  entry_index = '0;
  logic [ChanW-1:0]  red = '0;
  logic [ChanW-1:0]  green = '0;
  logic [ChanW-1:0]  blue = '0;
  logic [ColorW-1:0] color15 = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  logic [SlotW-1:0]  nearest_index_o;

  // palette mirror: red 7..0, green 15..8, blue 23..16
  logic [23:0]      palette_mirror [PaletteEntriesDef];
  logic [23:0]      tie_colours [4];
  logic [SlotW-1:0] expected_index [$];
  int               errors = 0;
  int               sender_idle_pct = 0;
  int               recv_stall_pct = 0;

  rgb555_nearest_palette_index u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation),
    .entry_index_i  (entry_index),
    .red_i          (red),
    .green_i        (green),
    .blue_i         (blue),
    .color15_i      (color15),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .nearest_index_o(nearest_index_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("rgb555_nearest_palette_index_test: done, errors");
    $finish;
  end

  // palette colour that an RGB555 value widens to (channel*8+4)
  function automatic logic [23:0] widened_rgb(logic [ColorW-1:0] c);
    return {c[14:10], 3'd4, c[9:5], 3'd4, c[4:0], 3'd4};
  endfunction

  function automatic logic [SlotW-1:0] nearest_slot(logic [ColorW-1:0] c);
    int qr, qg, qb, dr, dg, db, total, best_dist;
    logic [SlotW-1:0] best;
    qr = int'({c[4:0], 3'd4});
    qg = int'({c[9:5], 3'd4});
    qb = int'({c[14:10], 3'd4});
    best = '0;
    best_dist = 0;
    for (int n = 0; n < PaletteEntriesDef; n++) begin
      dr = qr - int'(palette_mirror[n][7:0]);
      dg = qg - int'(palette_mirror[n][15:8]);
      db = qb - int'(palette_mirror[n][23:16]);
      total = dr * dr + dg * dg + db * db;
      // strict compare keeps the lowest index on a tie
      if (n == 0 || total < best_dist) begin
        best = SlotW'(n);
        best_dist = total;
      end
    end
    return best;
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_beat(input logic op, input logic [SlotW-1:0] slot,
                           input logic [23:0] rgb, input logic [ColorW-1:0] c15);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    entry_index <= slot;
    red         <= rgb[7:0];
    green       <= rgb[15:8];
    blue        <= rgb[23:16];
    color15     <= c15;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OpLoad) begin
      if (slot < PaletteEntriesDef) palette_mirror[slot] = rgb;
    end else begin
      expected_index.push_back(nearest_slot(c15));
    end
  endtask

  // unused fields carry random junk
  task automatic load_entry(input logic [SlotW-1:0] slot, input logic [23:0] rgb);
    send_beat(OpLoad, slot, rgb, ColorW'($urandom));
  endtask

  task automatic query_colour(input logic [ColorW-1:0] c15);
    send_beat(OpQuery, SlotW'($urandom), 24'($urandom), c15);
  endtask

  function automatic logic [23:0] pick_entry_colour();
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return widened_rgb(ColorW'($urandom));
      2: return {($urandom_range(1) != 0) ? 8'hFF : 8'h00,
                 ($urandom_range(1) != 0) ? 8'hFF : 8'h00,
                 ($urandom_range(1) != 0) ? 8'hFF : 8'h00};
      default: return tie_colours[$urandom_range(3)];
    endcase
  endfunction

  // every slot is written before the first query; four colours repeat so
  // that most queries meet ties
  task automatic test_palette_fill();
    for (int k = 0; k < 4; k++) tie_colours[k] = widened_rgb(ColorW'($urandom));
    for (int n = 0; n < PaletteEntriesDef; n++) begin
      if (n == 7)
        load_entry(SlotW'(n), 24'h000000);
      else if (n == 200)
        load_entry(SlotW'(n), 24'hFFFFFF);
      else if (n == PaletteEntriesDef - 1)
        load_entry(SlotW'(n), widened_rgb(15'h4321));
      else
        load_entry(SlotW'(n), tie_colours[n % 4]);
    end
  endtask

  task automatic test_extreme_colours();
    query_colour(15'h0000);
    query_colour(15'h7FFF);
    query_colour(15'h001F);
    query_colour(15'h03E0);
    query_colour(15'h7C00);
    query_colour(15'h7FE0);
    query_colour(15'h03FF);
    query_colour(15'h5555);
    query_colour(15'h2AAA);
  endtask

  task automatic test_tie_breaking();
    for (int k = 0; k < 4; k++)
      query_colour({tie_colours[k][23:19], tie_colours[k][15:11], tie_colours[k][7:3]});
    // unique exact match in the top slot
    query_colour(15'h4321);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [23:0] near;
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
    for (int i = 0; i < PhaseBeats; i++) begin
      if ($urandom_range(99) < 35) begin
        load_entry(SlotW'($urandom), pick_entry_colour());
      end else if ($urandom_range(3) == 0) begin
        // query close to a stored entry
        near = palette_mirror[$urandom_range(PaletteEntriesDef - 1)];
        query_colour({near[23:19], near[15:11], near[7:3]});
      end else begin
        query_colour(ColorW'($urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_index.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual %0d",
                 $realtime, nearest_index_o);
        errors++;
      end else begin
        if (nearest_index_o !== expected_index[0]) begin
          $display("%0t: nearest_index mismatch: expected %0d, actual %0d",
                   $realtime, expected_index[0], nearest_index_o);
          errors++;
        end
        void'(expected_index.pop_front());
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_palette_fill();
    test_extreme_colours();
    test_tie_breaking();
    test_random_traffic(0, 0);
    test_random_traffic(80, 0);
    test_random_traffic(0, 80);
    test_random_traffic(16, 16);

    in_valid <= 1'b0;
    for (int i = 0; i < DrainLimit && expected_index.size() != 0; i++) @(posedge clk_i);
    repeat (ChainDelay) @(posedge clk_i);
    if (expected_index.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0",
               $realtime, expected_index.size());
      errors++;
    end

    if (errors == 0) begin
      $display("rgb555_nearest_palette_index_test: done, clean");
    end else begin
      $display("rgb555_nearest_palette_index_test: done, errors");
    end
    $finish;
  end

endmodule : rgb555_nearest_palette_index_test
